// ----- rtl/kar_pkg.sv -----
// ============================================================================
// kar_pkg - key auto-repeat scanner shared definitions
// Phase, event and operation codes, register indexes and the store write type.
// ============================================================================
package kar_pkg;

    localparam int KEY_W   = 6;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 1;

    typedef logic [2:0]        phase_t;
    typedef logic [1:0]        kind_t;
    typedef logic [1:0]        op_t;
    typedef logic [TIME_W-1:0] stamp_t;

    localparam phase_t PH_IDLE     = 3'd0;
    localparam phase_t PH_PRESSED  = 3'd1;
    localparam phase_t PH_FIRST    = 3'd2;
    localparam phase_t PH_REPEAT   = 3'd3;
    localparam phase_t PH_RELEASED = 3'd4;
    localparam phase_t PH_REL_IDLE = 3'd5;

    localparam kind_t EV_PRESSED  = 2'd0;
    localparam kind_t EV_REPEATED = 2'd1;
    localparam kind_t EV_RELEASED = 2'd2;

    localparam op_t OP_PRESS   = 2'd0;
    localparam op_t OP_RELEASE = 2'd1;
    localparam op_t OP_SCAN    = 2'd2;

    localparam logic [INDEX_W-1:0] REG_FIRST_DELAY     = 1'd0;
    localparam logic [INDEX_W-1:0] REG_REPEAT_INTERVAL = 1'd1;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST     = 16'd400;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd25;

    typedef struct packed {
        logic   phase_we;
        logic   stamp_we;
        phase_t phase;
        stamp_t stamp;
    } kar_wr_t;

endpackage

// ----- rtl/kar_if.sv -----
// ============================================================================
// kar_if - key auto-repeat scanner channels
// Key operation input, event output and configuration write channels.
// ============================================================================
interface kar_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  key_index;
    logic [31:0] time_ms;

    modport source (output valid, output operation, output key_index, output time_ms,
                    input ready);
    modport sink   (input valid, input operation, input key_index, input time_ms,
                    output ready);
endinterface

interface kar_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] event_key;
    logic [1:0] event_kind;
    logic       last;

    modport source (output valid, output event_key, output event_kind, output last,
                    input ready);
    modport sink   (input valid, input event_key, input event_kind, input last,
                    output ready);
endinterface

interface kar_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/kar_store.sv -----
// ============================================================================
// kar_store - per-key phase and stamp memory
// One write and one registered read port; phase entries carry valid bits so
// that an entry not written since reset reads as idle.
// ============================================================================
module kar_store #(
    parameter int NUM_KEYS = 64,
    parameter int KW       = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KW-1:0]    rd_addr,
    input  logic [KW-1:0]    wr_addr,
    input  kar_pkg::kar_wr_t wr,
    output kar_pkg::phase_t  rd_phase,
    output kar_pkg::stamp_t  rd_stamp
);
    import kar_pkg::*;

    phase_t              phase_mem [NUM_KEYS];
    stamp_t              stamp_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] vld_reg;
    phase_t              rd_phase_reg;
    stamp_t              rd_stamp_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr.phase_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.phase_we)
        begin
            phase_mem[wr_addr] <= wr.phase;
        end
        if (wr.stamp_we)
        begin
            stamp_mem[wr_addr] <= wr.stamp;
        end
        rd_phase_reg <= phase_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    assign rd_phase = rd_vld_reg ? rd_phase_reg : PH_IDLE;
    assign rd_stamp = rd_stamp_reg;

endmodule

// ----- rtl/key_autorepeat_scanner.sv -----
// ============================================================================
// key_autorepeat_scanner - per-key typematic auto-repeat engine
// Press and release update a key; a scan tick with an update pending walks all
// keys and emits pressed, repeated and released events.
//
//  channel  dir  handshake     payload
//  key_in   in   valid/ready   operation, key_index, time_ms
//  evt_out  out  valid/ready   event_key, event_kind, last
//  cfg      in   valid/ready   index, data (ready always high)
//
//  Release: direct write of the key's phase. Press: read of the key's phase, then update.
//  Scan: one key a cycle through the shared subtract and compare unit on the
//  single read port of the key store, unless output stalls hold the walk.
//  Reset leaves every key idle; no clearing pass. A full output register, a
//  held event and a new event stall the walk; the final event has last set.
// ============================================================================
module key_autorepeat_scanner #(
    parameter int NUM_KEYS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    kar_in_if.sink    key_in,
    kar_out_if.source evt_out,
    kar_cfg_if.sink   cfg
);
    import kar_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_KEYOP = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [KW-1:0]    scan_reg, scan_next;
    logic [KW-1:0]    key_reg, key_next;
    stamp_t           time_reg, time_next;
    logic             pending_reg, pending_next;
    logic             still_reg, still_next;
    logic [CFG_W-1:0] delay_reg, interval_reg;

    logic             held_vld_reg, held_vld_next;
    logic [KW-1:0]    held_key_reg, held_key_next;
    kind_t            held_kind_reg, held_kind_next;

    logic             out_vld_reg, out_vld_next;
    logic [KW-1:0]    out_key_reg, out_key_next;
    kind_t            out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;

    logic [KW-1:0]    rd_addr, wr_addr;
    kar_wr_t          wr;
    phase_t           rd_phase;
    stamp_t           rd_stamp;

    logic             accept, key_ok, out_free, out_load, advance, last_key;
    logic             hit, ev, still;
    kind_t            ev_kind;
    stamp_t           elapsed;
    logic [CFG_W-1:0] limit;

    kar_store #(
        .NUM_KEYS (NUM_KEYS),
        .KW       (KW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr       (wr),
        .rd_phase (rd_phase),
        .rd_stamp (rd_stamp)
    );

    assign key_in.ready = (state_reg == S_IDLE);
    assign accept       = key_in.valid && key_in.ready;
    assign key_ok       = {1'b0, key_in.key_index} < 7'(NUM_KEYS);
    assign out_free     = !out_vld_reg || evt_out.ready;
    assign last_key     = (scan_reg == KW'(NUM_KEYS - 1));

    // shared elapsed-time compare
    assign limit   = (rd_phase == PH_FIRST) ? delay_reg : interval_reg;
    assign elapsed = time_reg - rd_stamp;
    assign hit     = elapsed > {{(TIME_W-CFG_W){1'b0}}, limit};

    always_comb
    begin
        ev          = 1'b0;
        ev_kind     = EV_PRESSED;
        still       = 1'b0;
        wr.phase_we = 1'b0;
        wr.stamp_we = 1'b0;
        wr.phase    = PH_IDLE;
        wr.stamp    = time_reg;
        case (rd_phase)
            PH_PRESSED:
            begin
                ev          = 1'b1;
                still       = 1'b1;
                wr.phase_we = 1'b1;
                wr.phase    = PH_FIRST;
            end
            PH_FIRST:
            begin
                still = 1'b1;
                if (hit)
                begin
                    ev          = 1'b1;
                    ev_kind     = EV_REPEATED;
                    wr.phase_we = 1'b1;
                    wr.stamp_we = 1'b1;
                    wr.phase    = PH_REPEAT;
                end
            end
            PH_REPEAT:
            begin
                still = 1'b1;
                if (hit)
                begin
                    ev          = 1'b1;
                    ev_kind     = EV_REPEATED;
                    wr.stamp_we = 1'b1;
                end
            end
            PH_RELEASED:
            begin
                ev          = 1'b1;
                ev_kind     = EV_RELEASED;
                still       = 1'b1;
                wr.phase_we = 1'b1;
                wr.phase    = PH_REL_IDLE;
            end
            PH_REL_IDLE:
            begin
                wr.phase_we = 1'b1;
                wr.phase    = PH_IDLE;
            end
            default:
            begin
                ev = 1'b0;
            end
        endcase

        advance = !ev || !held_vld_reg || out_free;

        state_next     = state_reg;
        scan_next      = scan_reg;
        key_next       = key_reg;
        time_next      = time_reg;
        pending_next   = pending_reg;
        still_next     = still_reg;
        held_vld_next  = held_vld_reg;
        held_key_next  = held_key_reg;
        held_kind_next = held_kind_reg;
        out_load       = 1'b0;
        out_key_next   = out_key_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        rd_addr        = scan_reg;
        wr_addr        = scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                wr.phase_we = 1'b0;
                wr.stamp_we = 1'b0;
                rd_addr     = key_in.key_index[KW-1:0];
                wr_addr     = key_in.key_index[KW-1:0];
                wr.phase    = PH_RELEASED;
                time_next   = key_in.time_ms;
                key_next    = key_in.key_index[KW-1:0];
                if (accept)
                begin
                    case (key_in.operation)
                        OP_PRESS:
                        begin
                            if (key_ok)
                            begin
                                state_next = S_KEYOP;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (key_ok)
                            begin
                                wr.phase_we  = 1'b1;
                                pending_next = 1'b1;
                            end
                        end
                        OP_SCAN:
                        begin
                            if (pending_reg)
                            begin
                                rd_addr    = '0;
                                scan_next  = '0;
                                still_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_KEYOP:
            begin
                wr_addr      = key_reg;
                rd_addr      = key_reg;
                wr.phase     = PH_PRESSED;
                wr.stamp     = time_reg;
                wr.phase_we  = (rd_phase != PH_FIRST) && (rd_phase != PH_REPEAT);
                wr.stamp_we  = wr.phase_we;
                pending_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                if (!advance)
                begin
                    wr.phase_we = 1'b0;
                    wr.stamp_we = 1'b0;
                end
                else
                begin
                    if (ev)
                    begin
                        if (held_vld_reg)
                        begin
                            out_load      = 1'b1;
                            out_key_next  = held_key_reg;
                            out_kind_next = held_kind_reg;
                            out_last_next = 1'b0;
                        end
                        held_vld_next  = 1'b1;
                        held_key_next  = scan_reg;
                        held_kind_next = ev_kind;
                    end
                    still_next = still_reg || still;
                    if (last_key)
                    begin
                        pending_next = still_reg || still;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        scan_next = scan_reg + KW'(1);
                        rd_addr   = scan_reg + KW'(1);
                    end
                end
            end
            S_FIN:
            begin
                wr.phase_we = 1'b0;
                wr.stamp_we = 1'b0;
                if (!held_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_key_next  = held_key_reg;
                    out_kind_next = held_kind_reg;
                    out_last_next = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                wr.phase_we = 1'b0;
                wr.stamp_we = 1'b0;
                state_next  = S_IDLE;
            end
        endcase

        out_vld_next = out_load ? 1'b1 : (evt_out.ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pending_reg  <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            delay_reg    <= FIRST_DELAY_RST;
            interval_reg <= REPEAT_INTERVAL_RST;
        end
        else
        begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FIRST_DELAY:     delay_reg    <= cfg.data;
                    REG_REPEAT_INTERVAL: interval_reg <= cfg.data;
                    default:             delay_reg    <= delay_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        key_reg       <= key_next;
        time_reg      <= time_next;
        still_reg     <= still_next;
        held_key_reg  <= held_key_next;
        held_kind_reg <= held_kind_next;
        out_key_reg   <= out_key_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign cfg.ready          = 1'b1;
    assign evt_out.valid      = out_vld_reg;
    assign evt_out.event_key  = KEY_W'(out_key_reg);
    assign evt_out.event_kind = out_kind_reg;
    assign evt_out.last       = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_vld_reg)
        else $error("held event left over outside a scan");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_vld_reg || evt_out.ready))
        else $error("output register overwritten before transaction");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !advance) |=> (state_reg == S_SCAN && $stable(scan_reg)))
        else $error("key walk moved during stall");

    a_skip_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && key_in.operation == OP_SCAN && !pending_reg) |=> (state_reg == S_IDLE))
        else $error("scan started with nothing pending");
`endif

endmodule
